### hw/rtl/gssr_pkg.sv
// ----------------------------------------------------------------------------
// gssr_pkg
// Shared constants and types for the grouped serpentine strand remapper.
// ----------------------------------------------------------------------------
package gssr_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 256;
    localparam int MAX_GROUP   = 256;

    localparam int COLOR_W    = 24;
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 9;
    localparam int GRP_W      = 9;
    localparam int STRAND_W   = 8;
    localparam int BAND_W     = 8;
    localparam int POS_W      = 18;
    localparam int CNT_W      = $clog2(MAX_COLUMNS);
    localparam int STEP_W     = $clog2(ROWS_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int M_DATA_W   = 56;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 2'd3;

    localparam int RST_COLUMNS  = 16;
    localparam int RST_ROWS     = 16;
    localparam int RST_GROUP    = 1;
    localparam int RST_BANDS_M1 = RST_ROWS / RST_GROUP - 1;
    localparam int RST_BASE     = RST_BANDS_M1 * RST_COLUMNS;

    typedef struct packed {
        logic [CNT_W-1:0]    cols_m1;
        logic [COLS_W-1:0]   cols;
        logic [STRAND_W-1:0] group_m1;
        logic [BAND_W-1:0]   bands_m1;
        logic [POS_W-1:0]    base_load;
        logic                reverse;
        logic                bad;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0]  color;
        logic [POS_W-1:0]    position;
        logic [STRAND_W-1:0] strand;
        logic                frame_end;
        logic                config_error;
    } result_t;

endpackage

### hw/rtl/gssr_cfg.sv
// ----------------------------------------------------------------------------
// gssr_cfg
// Configuration registers and a bit-serial check of rows against group size.
// ----------------------------------------------------------------------------
module gssr_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gssr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gssr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output gssr_pkg::cfg_t                    cfg,
    output logic                              busy,
    output logic                              clear
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                      state_reg;
    logic [gssr_pkg::STEP_W-1:0]     step_reg;
    logic [gssr_pkg::COLS_W-1:0]     columns_reg;
    logic [gssr_pkg::ROWS_W-1:0]     rows_reg;
    logic [gssr_pkg::GRP_W-1:0]      group_reg;
    logic                            reverse_reg;
    logic [gssr_pkg::GRP_W-1:0]      rem_reg;
    logic [gssr_pkg::ROWS_W-1:0]     quo_reg;
    logic                            bad_reg;
    logic [gssr_pkg::BAND_W-1:0]     bands_m1_reg;
    logic [gssr_pkg::POS_W-1:0]      base_load_reg;

    logic [gssr_pkg::COLS_W-1:0]     eff_cols;
    logic [gssr_pkg::ROWS_W-1:0]     eff_rows;
    logic                            grp_bad;
    logic [gssr_pkg::GRP_W:0]        r_sh;
    logic [gssr_pkg::GRP_W:0]        r_diff;
    logic                            r_ge;
    logic [gssr_pkg::GRP_W-1:0]      rem_next;
    logic [gssr_pkg::ROWS_W-1:0]     quo_next;
    logic                            bad_next;
    logic [gssr_pkg::ROWS_W-1:0]     quo_m1;
    logic [gssr_pkg::BAND_W-1:0]     bands_m1_next;
    logic [gssr_pkg::BAND_W+gssr_pkg::COLS_W-1:0] prod;

    always_comb begin
        if (columns_reg == '0) begin
            eff_cols = gssr_pkg::COLS_W'(1);
        end else if (columns_reg > gssr_pkg::COLS_W'(gssr_pkg::MAX_COLUMNS)) begin
            eff_cols = gssr_pkg::COLS_W'(gssr_pkg::MAX_COLUMNS);
        end else begin
            eff_cols = columns_reg;
        end
        if (rows_reg == '0) begin
            eff_rows = gssr_pkg::ROWS_W'(1);
        end else if (rows_reg > gssr_pkg::ROWS_W'(gssr_pkg::MAX_ROWS)) begin
            eff_rows = gssr_pkg::ROWS_W'(gssr_pkg::MAX_ROWS);
        end else begin
            eff_rows = rows_reg;
        end
    end

    assign grp_bad = (group_reg == '0) || (group_reg > gssr_pkg::GRP_W'(gssr_pkg::MAX_GROUP));

    // restoring divide, one quotient bit per cycle
    assign r_sh     = {rem_reg, quo_reg[gssr_pkg::ROWS_W-1]};
    assign r_diff   = r_sh - {1'b0, group_reg};
    assign r_ge     = r_sh >= {1'b0, group_reg};
    assign rem_next = r_ge ? r_diff[gssr_pkg::GRP_W-1:0] : r_sh[gssr_pkg::GRP_W-1:0];
    assign quo_next = {quo_reg[gssr_pkg::ROWS_W-2:0], r_ge};

    assign bad_next      = grp_bad || (rem_reg != '0);
    assign quo_m1        = quo_reg - gssr_pkg::ROWS_W'(1);
    assign bands_m1_next = bad_next ? '0 : quo_m1[gssr_pkg::BAND_W-1:0];
    assign prod          = (gssr_pkg::BAND_W+gssr_pkg::COLS_W)'(bands_m1_next)
                         * (gssr_pkg::BAND_W+gssr_pkg::COLS_W)'(eff_cols);

    assign cfg_ready = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign clear     = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            columns_reg   <= gssr_pkg::COLS_W'(gssr_pkg::RST_COLUMNS);
            rows_reg      <= gssr_pkg::ROWS_W'(gssr_pkg::RST_ROWS);
            group_reg     <= gssr_pkg::GRP_W'(gssr_pkg::RST_GROUP);
            reverse_reg   <= 1'b0;
            bad_reg       <= 1'b0;
            bands_m1_reg  <= gssr_pkg::BAND_W'(gssr_pkg::RST_BANDS_M1);
            base_load_reg <= gssr_pkg::POS_W'(gssr_pkg::RST_BASE);
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_valid) begin
                        unique case (cfg_index)
                            gssr_pkg::REG_COLUMNS: begin
                                columns_reg <= cfg_data[gssr_pkg::COLS_W-1:0];
                            end
                            gssr_pkg::REG_ROWS: begin
                                rows_reg <= cfg_data[gssr_pkg::ROWS_W-1:0];
                            end
                            gssr_pkg::REG_GROUP: begin
                                group_reg <= cfg_data[gssr_pkg::GRP_W-1:0];
                            end
                            gssr_pkg::REG_REVERSE: begin
                                reverse_reg <= cfg_data[0];
                            end
                            default: begin
                            end
                        endcase
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    step_reg <= step_reg + gssr_pkg::STEP_W'(1);
                    if (step_reg == gssr_pkg::STEP_W'(gssr_pkg::ROWS_W - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    bad_reg       <= bad_next;
                    bands_m1_reg  <= bands_m1_next;
                    base_load_reg <= prod[gssr_pkg::POS_W-1:0];
                    state_reg     <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            rem_reg <= '0;
            quo_reg <= eff_rows;
        end else if (state_reg == ST_DIV) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_comb begin
        cfg.cols      = eff_cols;
        cfg.cols_m1   = gssr_pkg::CNT_W'(eff_cols - gssr_pkg::COLS_W'(1));
        cfg.group_m1  = gssr_pkg::STRAND_W'(group_reg - gssr_pkg::GRP_W'(1));
        cfg.bands_m1  = bands_m1_reg;
        cfg.base_load = base_load_reg;
        cfg.reverse   = reverse_reg;
        cfg.bad       = bad_reg;
    end

endmodule

### hw/rtl/gssr_map.sv
// ----------------------------------------------------------------------------
// gssr_map
// Column, strand and band counters and the per-pixel placement logic.
// ----------------------------------------------------------------------------
module gssr_map (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             clear,
    input  logic                             push,
    input  logic [gssr_pkg::COLOR_W-1:0]     color,
    input  logic                             frame_start,
    input  gssr_pkg::cfg_t                   cfg,
    output gssr_pkg::result_t                result
);

    logic [gssr_pkg::CNT_W-1:0]    col_reg;
    logic [gssr_pkg::STRAND_W-1:0] strand_reg;
    logic [gssr_pkg::BAND_W-1:0]   band_reg;
    logic [gssr_pkg::POS_W-1:0]    base_reg;

    logic [gssr_pkg::CNT_W-1:0]    col_cur;
    logic [gssr_pkg::STRAND_W-1:0] strand_cur;
    logic [gssr_pkg::BAND_W-1:0]   band_cur;
    logic [gssr_pkg::POS_W-1:0]    base_cur;
    logic [gssr_pkg::CNT_W-1:0]    col_eff;
    logic                          row_end;
    logic                          band_end;
    logic                          frame_end;

    logic [gssr_pkg::CNT_W-1:0]    col_next;
    logic [gssr_pkg::STRAND_W-1:0] strand_next;
    logic [gssr_pkg::BAND_W-1:0]   band_next;
    logic [gssr_pkg::POS_W-1:0]    base_next;

    always_comb begin
        if (frame_start) begin
            col_cur    = '0;
            strand_cur = '0;
            band_cur   = '0;
            base_cur   = cfg.base_load;
        end else begin
            col_cur    = col_reg;
            strand_cur = strand_reg;
            band_cur   = band_reg;
            base_cur   = base_reg;
        end

        // even bands run mirrored in reverse mode
        col_eff = (cfg.reverse && !band_cur[0]) ? (cfg.cols_m1 - col_cur) : col_cur;

        row_end   = (col_cur == cfg.cols_m1);
        band_end  = row_end && (strand_cur == cfg.group_m1);
        frame_end = band_end && (band_cur == cfg.bands_m1);

        col_next    = col_cur + gssr_pkg::CNT_W'(1);
        strand_next = strand_cur;
        band_next   = band_cur;
        base_next   = base_cur;
        if (row_end) begin
            col_next    = '0;
            strand_next = strand_cur + gssr_pkg::STRAND_W'(1);
            if (band_end) begin
                strand_next = '0;
                band_next   = band_cur + gssr_pkg::BAND_W'(1);
                base_next   = base_cur - gssr_pkg::POS_W'(cfg.cols);
                if (frame_end) begin
                    band_next = '0;
                    base_next = cfg.base_load;
                end
            end
        end

        result.color = color;
        if (cfg.bad) begin
            result.position     = '0;
            result.strand       = '0;
            result.frame_end    = 1'b0;
            result.config_error = 1'b1;
        end else begin
            result.position     = base_cur + gssr_pkg::POS_W'(col_eff);
            result.strand       = strand_cur;
            result.frame_end    = frame_end;
            result.config_error = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            col_reg    <= '0;
            strand_reg <= '0;
            band_reg   <= '0;
            base_reg   <= '0;
        end else if (push && !cfg.bad) begin
            col_reg    <= col_next;
            strand_reg <= strand_next;
            band_reg   <= band_next;
            base_reg   <= base_next;
        end
    end

endmodule

### hw/rtl/gssr_obuf.sv
// ----------------------------------------------------------------------------
// gssr_obuf
// Two-word output buffer: result register plus skid register.
// ----------------------------------------------------------------------------
module gssr_obuf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  gssr_pkg::result_t   in_word,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output gssr_pkg::result_t   out_word
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    gssr_pkg::result_t main_reg;
    gssr_pkg::result_t skid_reg;
    logic              pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_reg <= in_word;
            end else begin
                main_reg <= in_word;
            end
        end
    end

endmodule

### hw/rtl/grouped_serpentine_strand_remap.sv
// ----------------------------------------------------------------------------
// grouped_serpentine_strand_remap
// Maps raster-order frame pixels onto grouped, serpentine LED strands.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel, one word per pixel, with s_tuser marking
// the first pixel of a frame. Each pixel leaves on the m_ channel as one word
// holding its strand, position on that strand and color; m_tlast flags the
// last pixel of a frame and m_tuser flags an unusable configuration.
// The counter update and placement adder sit between the input handshake
// and the result register; a word that finds that register held goes to the
// skid register instead. Throughput is one pixel per cycle while s_tready is high.
// A two-word output buffer keeps s_tready high while one result waits, so a
// stalled receiver costs nothing until the second word backs up.
// A register write on the cfg_ channel clears the counters and starts a check
// of rows against group size (a 9-step serial divide), during which neither
// channel takes words. Reset loads the default sizes directly and the block
// is ready once aresetn rises.
// ----------------------------------------------------------------------------
module grouped_serpentine_strand_remap (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: pixel_color
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gssr_pkg::COLOR_W-1:0]        s_tdata,
    // s_tuser: frame_start
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: strand, strand_position, color, zero pad
    output logic [gssr_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    // m_tuser: config_error
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gssr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gssr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PAD_W = gssr_pkg::M_DATA_W - gssr_pkg::COLOR_W
                         - gssr_pkg::POS_W - gssr_pkg::STRAND_W;

    gssr_pkg::cfg_t    cfg;
    gssr_pkg::result_t map_word;
    gssr_pkg::result_t out_word;
    logic              busy;
    logic              clear;
    logic              buf_ready;
    logic              push;

    assign s_tready = buf_ready && !busy;
    assign push     = s_tvalid && s_tready;

    gssr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (busy),
        .clear     (clear)
    );

    gssr_map u_map (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (clear),
        .push        (push),
        .color       (s_tdata),
        .frame_start (s_tuser),
        .cfg         (cfg),
        .result      (map_word)
    );

    gssr_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .in_word   (map_word),
        .in_ready  (buf_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_word.color, out_word.position, out_word.strand};
    assign m_tlast = out_word.frame_end;
    assign m_tuser = out_word.config_error;

endmodule
